FILE: sv/zero_run_xor_decompressor_assert.svh
// ----------------------------------------------------------------------------
// zero_run_xor_decompressor_assert.svh
// assertion macros shared by the decompressor modules
// ----------------------------------------------------------------------------
`ifndef ZERO_RUN_XOR_DECOMPRESSOR_ASSERT_SVH
`define ZERO_RUN_XOR_DECOMPRESSOR_ASSERT_SVH

// same-cycle implication
`define ZRXD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zrxd check failed");

// next-cycle implication
`define ZRXD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zrxd check failed");

`endif

FILE: sv/zrxd_pkg.sv
// ----------------------------------------------------------------------------
// zrxd_pkg
// shared types and constants of the zero-run / xor-delta decompressor
// ----------------------------------------------------------------------------
`default_nettype none

package zrxd_pkg;

    localparam int HISTORY_DEPTH_DEF = 32;
    localparam int LANE_BYTES_DEF    = 8;

    localparam int OUT_BYTES_W = 64;
    localparam int COUNT_W     = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [4:0] SYM_BITS    = 5'd9;
    localparam logic [4:0] BYTE_BITS   = 5'd8;
    localparam int         LIT_FLAG_BIT = 8;

    typedef enum logic [1:0] {
        CMD_PASS   = 2'd0,
        CMD_LIT    = 2'd1,
        CMD_RUN    = 2'd2,
        CMD_STATUS = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  value;
        logic        fin;
        logic        aerr;
        logic        clear_hist;
    } cmd_t;

    typedef struct packed {
        logic [OUT_BYTES_W-1:0] out_bytes;
        logic [COUNT_W-1:0]     byte_count;
        logic                   last_of_run;
        logic                   finished;
        logic                   align_error;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/zrxd_front.sv
// ----------------------------------------------------------------------------
// zrxd_front
// bit unpacking and symbol classification, one command per request at most
// ----------------------------------------------------------------------------
`default_nettype none

`include "zero_run_xor_decompressor_assert.svh"

module zrxd_front
    import zrxd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_wr_en,
    input  wire logic cfg_wr_data,
    input  wire logic item_valid,
    output logic      item_ready,
    input  wire logic [7:0] item_byte,
    input  wire logic item_block_end,
    input  wire logic item_download_start,
    input  wire logic queue_full,
    output logic      push,
    output cmd_t      push_cmd
);

    logic       enable_reg;
    logic [7:0] acc_reg, acc_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       ended_reg, ended_next;
    logic       clr_reg, clr_next;

    logic        take;
    logic [15:0] acc_w;
    logic [4:0]  cnt_w;
    logic [4:0]  left;
    logic [8:0]  sym;
    logic        have_sym;
    logic        fin;
    logic        aerr;
    logic        is_lit;
    logic        is_run;

    assign item_ready = !queue_full;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        ended_next = ended_reg;
        clr_next   = clr_reg;
        push       = 1'b0;
        push_cmd   = '{kind: CMD_PASS, value: item_byte, fin: 1'b0, aerr: 1'b0,
                       clear_hist: 1'b0};
        acc_w      = '0;
        cnt_w      = '0;
        left       = '0;
        sym        = '0;
        have_sym   = 1'b0;
        fin        = 1'b0;
        aerr       = 1'b0;
        is_lit     = 1'b0;
        is_run     = 1'b0;
        if (take)
        begin
            if (item_download_start)
            begin
                acc_next   = '0;
                cnt_next   = '0;
                ended_next = 1'b0;
                clr_next   = 1'b1;
            end
            if (!enable_reg)
            begin
                push = 1'b1;
            end
            else if (!ended_next)
            begin
                acc_w = {acc_next, item_byte};
                cnt_w = {1'b0, cnt_next} + BYTE_BITS;
                if (cnt_w >= SYM_BITS)
                begin
                    left     = cnt_w - SYM_BITS;
                    sym      = 9'(acc_w >> left);
                    have_sym = 1'b1;
                end
                else
                begin
                    left = cnt_w;
                end
                fin    = have_sym && (sym == 9'd0);
                is_lit = have_sym && sym[LIT_FLAG_BIT];
                is_run = have_sym && !sym[LIT_FLAG_BIT] && (sym != 9'd0);
                aerr   = item_block_end && (left != 5'd0);
                if (item_block_end || fin)
                begin
                    acc_next = '0;
                    cnt_next = '0;
                end
                else
                begin
                    acc_next = acc_w[7:0];
                    cnt_next = left[3:0];
                end
                if (fin)
                begin
                    ended_next = 1'b1;
                end
                push_cmd.fin   = fin;
                push_cmd.aerr  = aerr;
                push_cmd.value = sym[7:0];
                if (is_lit || is_run)
                begin
                    push                = 1'b1;
                    push_cmd.kind       = is_lit ? CMD_LIT : CMD_RUN;
                    push_cmd.clear_hist = clr_next;
                    clr_next            = 1'b0;
                end
                else if (fin || aerr)
                begin
                    push          = 1'b1;
                    push_cmd.kind = CMD_STATUS;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            ended_reg  <= 1'b0;
            clr_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                enable_reg <= cfg_wr_data;
            end
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            ended_reg <= ended_next;
            clr_reg   <= clr_next;
        end
    end

    // ended stream swallows requests until a new download
    `ZRXD_ASSERT_IMPLIES(a_ended_silent, clk, rst_n,
        take && enable_reg && ended_reg && !item_download_start, !push)
    `ZRXD_ASSERT_NEXT(a_fin_ends, clk, rst_n, push && push_cmd.fin, ended_reg)
    `ZRXD_ASSERT_IMPLIES(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= BYTE_BITS[3:0])

endmodule

`default_nettype wire

FILE: sv/zrxd_fifo.sv
// ----------------------------------------------------------------------------
// zrxd_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

`include "zero_run_xor_decompressor_assert.svh"

module zrxd_fifo
    import zrxd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      head,
    output logic      empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ZRXD_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !full || pop)
    `ZRXD_ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, !empty)
    `ZRXD_ASSERT_IMPLIES(a_full_not_empty, clk, rst_n, full, !empty)

endmodule

`default_nettype wire

FILE: sv/zrxd_back.sv
// ----------------------------------------------------------------------------
// zrxd_back
// run expansion, xor delta against the history line and lane packing
// ----------------------------------------------------------------------------
`default_nettype none

`include "zero_run_xor_decompressor_assert.svh"

module zrxd_back
    import zrxd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int LANE_BYTES    = LANE_BYTES_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic queue_empty,
    input  wire cmd_t head,
    output logic      pop,
    output logic      res_valid,
    input  wire logic res_ready,
    output res_t      res
);

    localparam int FILL_W = (LANE_BYTES > 1) ? $clog2(LANE_BYTES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    typedef logic [LANE_BYTES-1:0][7:0] lane_t;

    state_t                         state_reg, state_next;
    logic [7:0]                     rem_reg, rem_next;
    logic [7:0]                     data_reg, data_next;
    logic                           fin_reg, fin_next;
    logic                           aerr_reg, aerr_next;
    logic [FILL_W-1:0]              fill_reg, fill_next;
    lane_t                          lane_reg, lane_next;
    logic [HISTORY_DEPTH-1:0][7:0]  hist_reg;
    logic                           out_valid_reg;
    res_t                           out_reg;

    logic   out_free;
    logic   emit;
    res_t   emit_res;
    logic   hist_shift;
    logic   hist_clear;
    logic [7:0] byte_v;
    lane_t  lane_w;
    logic   lane_done;
    logic   run_last;

    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign byte_v    = data_reg ^ hist_reg[HISTORY_DEPTH-1];
    assign lane_done = (fill_reg == FILL_W'(LANE_BYTES - 1));
    assign run_last  = (rem_reg == 8'd1);

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        data_next  = data_reg;
        fin_next   = fin_reg;
        aerr_next  = aerr_reg;
        fill_next  = fill_reg;
        lane_next  = lane_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        emit_res   = '0;
        hist_shift = 1'b0;
        hist_clear = 1'b0;
        lane_w     = lane_reg;
        lane_w[fill_reg] = byte_v;
        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    case (head.kind)
                        CMD_PASS:
                        begin
                            if (out_free)
                            begin
                                pop                  = 1'b1;
                                emit                 = 1'b1;
                                emit_res.out_bytes   = OUT_BYTES_W'(head.value);
                                emit_res.byte_count  = COUNT_W'(1);
                                emit_res.last_of_run = 1'b1;
                            end
                        end
                        CMD_STATUS:
                        begin
                            if (out_free)
                            begin
                                pop                  = 1'b1;
                                emit                 = 1'b1;
                                emit_res.last_of_run = 1'b1;
                                emit_res.finished    = head.fin;
                                emit_res.align_error = head.aerr;
                            end
                        end
                        CMD_LIT, CMD_RUN:
                        begin
                            pop        = 1'b1;
                            hist_clear = head.clear_hist;
                            data_next  = (head.kind == CMD_LIT) ? head.value : 8'd0;
                            rem_next   = (head.kind == CMD_LIT) ? 8'd1 : head.value;
                            fin_next   = head.fin;
                            aerr_next  = head.aerr;
                            state_next = ST_RUN;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (!(lane_done || run_last) || out_free)
                begin
                    hist_shift = 1'b1;
                    rem_next   = rem_reg - 8'd1;
                    if (lane_done || run_last)
                    begin
                        emit                 = 1'b1;
                        emit_res.out_bytes   = OUT_BYTES_W'(lane_w);
                        emit_res.byte_count  = COUNT_W'(fill_reg) + COUNT_W'(1);
                        emit_res.last_of_run = run_last;
                        emit_res.finished    = run_last && fin_reg;
                        emit_res.align_error = run_last && aerr_reg;
                        lane_next            = '0;
                        fill_next            = '0;
                    end
                    else
                    begin
                        lane_next = lane_w;
                        fill_next = fill_reg + 1'b1;
                    end
                    if (run_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else if (hist_clear)
        begin
            hist_reg <= '0;
        end
        else if (hist_shift)
        begin
            for (int i = HISTORY_DEPTH - 1; i > 0; i--)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
            hist_reg[0] <= byte_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rem_reg       <= '0;
            fill_reg      <= '0;
            lane_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            fill_reg  <= fill_next;
            lane_reg  <= lane_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        fin_reg  <= fin_next;
        aerr_reg <= aerr_next;
        if (emit)
        begin
            out_reg <= emit_res;
        end
    end

    // status-only results always close a request
    `ZRXD_ASSERT_IMPLIES(a_status_last, clk, rst_n,
        out_valid_reg && (out_reg.byte_count == '0),
        out_reg.last_of_run && (out_reg.finished || out_reg.align_error))
    `ZRXD_ASSERT_IMPLIES(a_flags_last, clk, rst_n,
        out_valid_reg && (out_reg.finished || out_reg.align_error), out_reg.last_of_run)
    `ZRXD_ASSERT_IMPLIES(a_run_nonzero, clk, rst_n, state_reg == ST_RUN, rem_reg != 8'd0)

endmodule

`default_nettype wire

FILE: sv/zero_run_xor_decompressor.sv
// ----------------------------------------------------------------------------
// zero_run_xor_decompressor
// unpacks 9-bit zero-run symbols, applies the xor delta and packs bytes
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one compressed byte per request, tlast marks a block end,
//   tuser marks the first byte of a download and resets the front's state.
//   m_axis carries results of up to LANE_BYTES bytes; tlast marks the final
//   result of a request, tuser flags end of stream and block misalignment.
//   cfg_wr_en/cfg_wr_data write the decompress enable (reset 1); write it
//   only while the block is idle. with it cleared, bytes pass through 1:1.
// path: a pass-through or status result passes the command queue and output
//   register, a literal also the run state. a run of n zero bytes is expanded
//   at one byte per cycle through the history line while m_axis takes results,
//   giving ceil(n/LANE_BYTES) results. the front takes one byte per cycle
//   while the 2-entry command queue has room; long runs hold s_axis_tready low.
// reset: async, clears history, bit buffer, queue and output valid flag.
// a stalled m_axis holds its result; the back stops at the next full lane or
//   run end, and the queue then fills and back-pressures the input.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_run_xor_decompressor
    import zrxd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int LANE_BYTES    = LANE_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte
    input  wire logic        s_axis_tlast,
    input  wire logic        s_axis_tuser,   // download_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // out_bytes, byte_count, zero pad
    output logic             m_axis_tlast,
    output logic [1:0]       m_axis_tuser    // finished, align_error
);

    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    cmd_t head;
    logic empty;
    res_t res;

    zrxd_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .item_valid          (s_axis_tvalid),
        .item_ready          (s_axis_tready),
        .item_byte           (s_axis_tdata),
        .item_block_end      (s_axis_tlast),
        .item_download_start (s_axis_tuser),
        .queue_full          (full),
        .push                (push),
        .push_cmd            (push_cmd)
    );

    zrxd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    zrxd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .LANE_BYTES    (LANE_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (empty),
        .head        (head),
        .pop         (pop),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res         (res)
    );

    assign m_axis_tdata = {4'b0000, res.byte_count, res.out_bytes};
    assign m_axis_tlast = res.last_of_run;
    assign m_axis_tuser = {res.align_error, res.finished};

endmodule

`default_nettype wire
